>>> hdl/dcls_pkg.sv
// Shared types, constants and helpers for the Dirichlet count and log score block.
// Depends on nothing; imported by the top level.
package dcls_pkg;

    localparam int MAX_COLUMNS = 8;
    localparam int ALPHABET    = 4;
    localparam int COUNT_BITS  = 16;
    localparam int ROW_WORDS   = ALPHABET + 1;
    localparam int TBL_DEPTH   = MAX_COLUMNS * ROW_WORDS;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int COL_BITS    = 3;
    localparam int PRIOR_BITS  = 18;
    localparam int NUM_BITS    = COUNT_BITS + 9;
    localparam int LOG_BITS    = 21;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [31:0]           LN2_Q32   = 32'd2977044472;
    localparam logic [31:0]           ACC_MIN   = 32'h8000_0000;
    localparam logic [2:0]            SUM_SLOT  = 3'(ALPHABET);
    localparam logic [3:0]            COLS_MAX  = 4'(MAX_COLUMNS);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SCORE  = 2'd2,
        OP_LOAD   = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [1:0]  symbol;
        logic [2:0]  prior_column;
        logic [15:0] prior_value;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] log_score;
        logic [15:0]        observations;
        logic               status;
    } out_item_t;

    // Word address of entry k of a column row; entry ALPHABET holds the row sum.
    function automatic logic [TBL_AW-1:0] tbl_addr(logic [COL_BITS-1:0] col, logic [2:0] k);
        tbl_addr = TBL_AW'(int'(col) * ROW_WORDS + int'(k));
    endfunction

endpackage

>>> hdl/dirichlet_count_log_score.sv
// Add, remove and load keep the input stalled until their work is done, and so does a
// score symbol, whose two log2 evaluations, when both run, take 16 square steps each.
// A symbol that ends a word adds a bit-serial division of the symbol count by the
// column count, then the result is registered; one item is worked on at a time.
// Reset (rst_n, asynchronous) clears both tables through per-entry valid bits, the
// word state and the result register; cols_reg returns to 8.
module dirichlet_count_log_score
    import dcls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ADD_RD_SYM, ST_ADD_RD_TOT, ST_ADD_CHECK, ST_ADD_WR_TOT,
        ST_SC_RD_SYM, ST_SC_RD_TOT, ST_SC_SETUP, ST_NORM, ST_SQUARE, ST_REDUCE,
        ST_MAG, ST_ACC, ST_LD_WR, ST_LD_RD, ST_LD_ADD, ST_LD_WR_SUM,
        ST_STEP, ST_DIV, ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]            cols_reg;
    logic [COL_BITS-1:0]   pos_reg, pos_next;
    logic [31:0]           acc_reg, acc_next;
    logic [15:0]           sym_cnt_reg, sym_cnt_next;
    logic                  sat_reg, sat_next;
    opcode_t               op_reg, op_next;
    logic [1:0]            sym_reg, sym_next;
    logic [COL_BITS-1:0]   pcol_reg, pcol_next;
    logic [15:0]           pval_reg, pval_next;
    logic                  last_reg, last_next;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [COUNT_BITS-1:0] cs_reg, cs_next, ct_reg, ct_next;
    logic [PRIOR_BITS-1:0] ps_reg, ps_next, psum_reg, psum_next;
    logic [NUM_BITS-1:0]   d_reg, d_next;
    logic [31:0]           m_reg, m_next;
    logic [4:0]            e_reg, e_next;
    logic [15:0]           frac_reg, frac_next;
    logic [3:0]            it_reg, it_next;
    logic                  which_reg, which_next;
    logic [LOG_BITS-1:0]   ln_reg, ln_next;
    logic [63:0]           prod_reg, prod_next;
    logic [1:0]            k_reg, k_next;
    logic [15:0]           quo_reg, quo_next;
    logic [3:0]            rem_reg, rem_next;
    logic [3:0]            dcnt_reg, dcnt_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;

    logic [TBL_DEPTH-1:0] cnt_vld_reg, pri_vld_reg;
    logic                 cnt_vq_reg, pri_vq_reg;

    logic                  cnt_we, pri_we;
    logic [TBL_AW-1:0]     cnt_waddr, cnt_raddr, pri_waddr, pri_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_ram_q, cnt_rd;
    logic [PRIOR_BITS-1:0] pri_wdata, pri_ram_q, pri_rd;

    logic [3:0]            eff;
    logic [COL_BITS-1:0]   in_col;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           mul_p;
    logic [LOG_BITS-1:0]   mag;
    logic [LOG_BITS-1:0]   logv;
    logic [31:0]           m2;
    logic [15:0]           frac_new;
    logic [NUM_BITS-1:0]   num, den;
    logic [63:0]           rounded;
    logic signed [32:0]    diff;
    logic [4:0]            div_r;
    logic [15:0]           cnt_inc;
    logic [3:0]            col_inc;

    dcls_ram #(.WIDTH(COUNT_BITS), .DEPTH(TBL_DEPTH)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_ram_q)
    );

    dcls_ram #(.WIDTH(PRIOR_BITS), .DEPTH(TBL_DEPTH)) u_pri_ram (
        .clk(clk), .we(pri_we), .waddr(pri_waddr), .wdata(pri_wdata),
        .raddr(pri_raddr), .rdata(pri_ram_q)
    );

    // Entries never written since reset read as zero.
    assign cnt_rd = cnt_vq_reg ? cnt_ram_q : '0;
    assign pri_rd = pri_vq_reg ? pri_ram_q : '0;

    always_comb
    begin
        if (cols_reg == 4'd0)
        begin
            eff = 4'd1;
        end
        else if (cols_reg > COLS_MAX)
        begin
            eff = COLS_MAX;
        end
        else
        begin
            eff = cols_reg;
        end
    end

    assign in_col   = ({1'b0, pos_reg} >= eff) ? '0 : pos_reg;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The one shared multiplier: mantissa squares, and the final scale by ln 2.
    assign mag   = (ln_reg > logv) ? '0 : logv - ln_reg;
    assign mul_a = (state_reg == ST_MAG) ? 32'(mag) : m_reg;
    assign mul_b = (state_reg == ST_MAG) ? LN2_Q32 : m_reg;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign m2       = prod_reg[61:30];
    assign frac_new = {frac_reg[14:0], m2[31]};
    assign num      = NUM_BITS'({cs_reg, 8'b0}) + NUM_BITS'(ps_reg);
    assign den      = NUM_BITS'({cnt_rd, 8'b0}) + NUM_BITS'(pri_rd);
    assign rounded  = prod_reg + 64'h0000_0000_8000_0000;
    assign diff     = 33'(signed'(acc_reg)) - 33'(signed'({1'b0, rounded[63:32]}));
    assign div_r    = {rem_reg, quo_reg[15]};
    assign cnt_inc  = (sym_cnt_reg == 16'hFFFF) ? sym_cnt_reg : sym_cnt_reg + 16'd1;
    assign col_inc  = {1'b0, col_reg} + 4'd1;

    // In the log state chain the upper log is held in ln_reg until the second one is done.
    always_comb
    begin
        if (state_reg == ST_MAG)
        begin
            logv = {e_reg, frac_reg};
        end
        else
        begin
            logv = {e_reg, frac_new};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        sym_cnt_next   = sym_cnt_reg;
        sat_next       = sat_reg;
        op_next        = op_reg;
        sym_next       = sym_reg;
        pcol_next      = pcol_reg;
        pval_next      = pval_reg;
        last_next      = last_reg;
        col_next       = col_reg;
        cs_next        = cs_reg;
        ct_next        = ct_reg;
        ps_next        = ps_reg;
        psum_next      = psum_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        frac_next      = frac_reg;
        it_next        = it_reg;
        which_next     = which_reg;
        ln_next        = ln_reg;
        prod_next      = prod_reg;
        k_next         = k_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        cnt_we    = 1'b0;
        cnt_waddr = tbl_addr(col_reg, {1'b0, sym_reg});
        cnt_wdata = cs_reg;
        cnt_raddr = tbl_addr(col_reg, {1'b0, sym_reg});
        pri_we    = 1'b0;
        pri_waddr = tbl_addr(pcol_reg, {1'b0, sym_reg});
        pri_wdata = PRIOR_BITS'(pval_reg);
        pri_raddr = tbl_addr(col_reg, {1'b0, sym_reg});

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_data.opcode;
                    sym_next  = in_data.symbol;
                    pcol_next = in_data.prior_column;
                    pval_next = in_data.prior_value;
                    last_next = in_data.last;
                    col_next  = in_col;
                    unique case (in_data.opcode)
                        OP_ADD, OP_REMOVE: state_next = ST_ADD_RD_SYM;
                        OP_SCORE:
                        begin
                            state_next = (acc_reg == ACC_MIN) ? ST_STEP : ST_SC_RD_SYM;
                        end
                        OP_LOAD: state_next = ST_LD_WR;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD_SYM:
            begin
                state_next = ST_ADD_RD_TOT;
            end
            ST_ADD_RD_TOT:
            begin
                cnt_raddr  = tbl_addr(col_reg, SUM_SLOT);
                cs_next    = cnt_rd;
                state_next = ST_ADD_CHECK;
            end
            ST_ADD_CHECK:
            begin
                ct_next = cnt_rd;
                if ((op_reg == OP_ADD && (cs_reg == COUNT_MAX || cnt_rd == COUNT_MAX)) ||
                    (op_reg == OP_REMOVE && (cs_reg == '0 || cnt_rd == '0)))
                begin
                    sat_next   = 1'b1;
                    state_next = ST_STEP;
                end
                else
                begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = (op_reg == OP_ADD) ? cs_reg + 1'b1 : cs_reg - 1'b1;
                    state_next = ST_ADD_WR_TOT;
                end
            end
            ST_ADD_WR_TOT:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = tbl_addr(col_reg, SUM_SLOT);
                cnt_wdata  = (op_reg == OP_ADD) ? ct_reg + 1'b1 : ct_reg - 1'b1;
                state_next = ST_STEP;
            end
            ST_SC_RD_SYM:
            begin
                state_next = ST_SC_RD_TOT;
            end
            ST_SC_RD_TOT:
            begin
                cnt_raddr  = tbl_addr(col_reg, SUM_SLOT);
                pri_raddr  = tbl_addr(col_reg, SUM_SLOT);
                cs_next    = cnt_rd;
                ps_next    = pri_rd;
                state_next = ST_SC_SETUP;
            end
            ST_SC_SETUP:
            begin
                if (num == '0 || den == '0)
                begin
                    acc_next   = ACC_MIN;
                    state_next = ST_STEP;
                end
                else
                begin
                    m_next     = 32'(num);
                    d_next     = den;
                    e_next     = 5'd30;
                    which_next = 1'b0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // Bring the leading one to bit 30, four places a cycle while possible.
                if (m_reg[30])
                begin
                    it_next    = '0;
                    frac_next  = '0;
                    state_next = ST_SQUARE;
                end
                else if (m_reg[30:27] == 4'b0)
                begin
                    m_next = {m_reg[27:0], 4'b0};
                    e_next = e_reg - 5'd4;
                end
                else
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            ST_SQUARE:
            begin
                prod_next  = mul_p;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                frac_next = frac_new;
                m_next    = m2[31] ? {1'b0, m2[31:1]} : m2;
                it_next   = it_reg + 4'd1;
                if (it_reg == 4'd15)
                begin
                    if (!which_reg)
                    begin
                        ln_next    = logv;
                        m_next     = 32'(d_reg);
                        e_next     = 5'd30;
                        which_next = 1'b1;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        state_next = ST_MAG;
                    end
                end
                else
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_MAG:
            begin
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (diff < -33'sd2147483648)
                begin
                    acc_next = ACC_MIN;
                end
                else
                begin
                    acc_next = diff[31:0];
                end
                state_next = ST_STEP;
            end
            ST_LD_WR:
            begin
                pri_we     = 1'b1;
                k_next     = '0;
                psum_next  = '0;
                state_next = ST_LD_RD;
            end
            ST_LD_RD:
            begin
                pri_raddr  = tbl_addr(pcol_reg, {1'b0, k_reg});
                state_next = ST_LD_ADD;
            end
            ST_LD_ADD:
            begin
                psum_next  = psum_reg + pri_rd;
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? ST_LD_WR_SUM : ST_LD_RD;
            end
            ST_LD_WR_SUM:
            begin
                pri_we     = 1'b1;
                pri_waddr  = tbl_addr(pcol_reg, SUM_SLOT);
                pri_wdata  = psum_reg;
                state_next = ST_IDLE;
            end
            ST_STEP:
            begin
                pos_next     = (col_inc >= eff) ? '0 : col_inc[COL_BITS-1:0];
                sym_cnt_next = cnt_inc;
                if (last_reg)
                begin
                    quo_next   = cnt_inc;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                // Restoring division of the symbol count by the column count, one bit a cycle.
                if (div_r >= {1'b0, eff})
                begin
                    rem_next = 4'(div_r - {1'b0, eff});
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = div_r[3:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == 4'd15)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.log_score    = acc_reg;
                    out_data_next.observations = quo_reg;
                    out_data_next.status       = sat_reg;
                    pos_next                   = '0;
                    acc_next                   = '0;
                    sym_cnt_next               = '0;
                    sat_next                   = 1'b0;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            acc_reg       <= '0;
            sym_cnt_reg   <= '0;
            sat_reg       <= 1'b0;
            op_reg        <= OP_ADD;
            sym_reg       <= '0;
            pcol_reg      <= '0;
            pval_reg      <= '0;
            last_reg      <= 1'b0;
            col_reg       <= '0;
            cs_reg        <= '0;
            ct_reg        <= '0;
            ps_reg        <= '0;
            psum_reg      <= '0;
            d_reg         <= '0;
            m_reg         <= '0;
            e_reg         <= '0;
            frac_reg      <= '0;
            it_reg        <= '0;
            which_reg     <= 1'b0;
            ln_reg        <= '0;
            prod_reg      <= '0;
            k_reg         <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            sym_cnt_reg   <= sym_cnt_next;
            sat_reg       <= sat_next;
            op_reg        <= op_next;
            sym_reg       <= sym_next;
            pcol_reg      <= pcol_next;
            pval_reg      <= pval_next;
            last_reg      <= last_next;
            col_reg       <= col_next;
            cs_reg        <= cs_next;
            ct_reg        <= ct_next;
            ps_reg        <= ps_next;
            psum_reg      <= psum_next;
            d_reg         <= d_next;
            m_reg         <= m_next;
            e_reg         <= e_next;
            frac_reg      <= frac_next;
            it_reg        <= it_next;
            which_reg     <= which_next;
            ln_reg        <= ln_next;
            prod_reg      <= prod_next;
            k_reg         <= k_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= COLS_MAX;
            cnt_vld_reg <= '0;
            pri_vld_reg <= '0;
            cnt_vq_reg  <= 1'b0;
            pri_vq_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cols_reg <= cfg_wdata;
            end
            if (cnt_we)
            begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
            if (pri_we)
            begin
                pri_vld_reg[pri_waddr] <= 1'b1;
            end
            cnt_vq_reg <= cnt_vld_reg[cnt_raddr];
            pri_vq_reg <= pri_vld_reg[pri_raddr];
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ST_IDLE)
        else $error("accepted transfer did not start work");

    a_acc_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg[31] |-> acc_reg == '0)
        else $error("score accumulator became positive");

    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQUARE |-> m_reg[31:30] == 2'b01)
        else $error("log mantissa left its normalized range");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && state_next == ST_IDLE |=> out_valid_reg && sym_cnt_reg == '0)
        else $error("word result emitted without clearing the word state");

endmodule

>>> hdl/dcls_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module dcls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> dv/dirichlet_count_log_score_tb.sv
// Self-checking testbench for dirichlet_count_log_score: random symbol words with
// gaps on both sides are scored against a built-in predictor of the count tables.
// Depends on dcls_pkg and the dirichlet_count_log_score RTL.
module dirichlet_count_log_score_tb;
    import dcls_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [3:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    dirichlet_count_log_score DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // Predictor state.
    longint unsigned count_tab [MAX_COLUMNS][ALPHABET+1];
    longint unsigned prior_tab [MAX_COLUMNS][ALPHABET+1];
    int unsigned     word_col;
    longint          word_score;
    int unsigned     word_len;
    bit              word_sat;
    int unsigned     cols_reg;

    in_item_t  pending_items[$];
    out_item_t expected_scores[$];
    bit        fail_seen = 1'b0;
    int        hold_request = 0;
    int        idle_cycles = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic void add_pending(in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic longint unsigned log2_fixed(longint unsigned x);
        int e;
        longint unsigned m;
        longint unsigned frac;
        e = 63;
        frac = 0;
        while (e > 0 && x[e] == 1'b0)
            e--;
        if (e >= 30)
            m = x >> (e - 30);
        else
            m = x << (30 - e);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    task automatic predict_transfer(input in_item_t it);
        int unsigned eff;
        int unsigned col;
        longint unsigned num, den, mag, ln_n, ln_d;
        out_item_t res;
        if (it.opcode == OP_LOAD) begin
            prior_tab[it.prior_column][it.symbol] = it.prior_value;
            prior_tab[it.prior_column][ALPHABET] = (prior_tab[it.prior_column][0]
                + prior_tab[it.prior_column][1] + prior_tab[it.prior_column][2]
                + prior_tab[it.prior_column][3]) & 18'h3FFFF;
            return;
        end
        eff = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLUMNS ? MAX_COLUMNS : cols_reg);
        col = (word_col >= eff) ? 0 : word_col;
        case (it.opcode)
            OP_ADD: begin
                if (count_tab[col][it.symbol] >= COUNT_MAX
                        || count_tab[col][ALPHABET] >= COUNT_MAX)
                    word_sat = 1'b1;
                else begin
                    count_tab[col][it.symbol]++;
                    count_tab[col][ALPHABET]++;
                end
            end
            OP_REMOVE: begin
                if (count_tab[col][it.symbol] == 0 || count_tab[col][ALPHABET] == 0)
                    word_sat = 1'b1;
                else begin
                    count_tab[col][it.symbol]--;
                    count_tab[col][ALPHABET]--;
                end
            end
            default: begin
                if (word_score > -64'sd2147483648) begin
                    num = (count_tab[col][it.symbol] << 8) + prior_tab[col][it.symbol];
                    den = (count_tab[col][ALPHABET] << 8) + prior_tab[col][ALPHABET];
                    if (num == 0 || den == 0)
                        word_score = -64'sd2147483648;
                    else begin
                        ln_n = log2_fixed(num);
                        ln_d = log2_fixed(den);
                        mag = (ln_d > ln_n) ? ln_d - ln_n : 0;
                        mag = (mag * 64'd2977044472 + 64'h8000_0000) >> 32;
                        word_score -= longint'(mag);
                        if (word_score < -64'sd2147483648)
                            word_score = -64'sd2147483648;
                    end
                end
            end
        endcase
        word_col = (col + 1 >= eff) ? 0 : col + 1;
        if (word_len < 65535)
            word_len++;
        if (it.last) begin
            res.log_score = word_score[31:0];
            res.observations = 16'(word_len / eff);
            res.status = word_sat;
            expected_scores.insert(expected_scores.size(), res);
            word_col = 0;
            word_score = 0;
            word_len = 0;
            word_sat = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Driver: inputs change on the falling edge.
    bit accepted_in = 1'b0;
    int send_gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !accepted_in) begin
                // Hold the stalled transfer unchanged.
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with a long hold-off each time one is requested.
    int hold_left = 0;
    int hold_taken = 0;
    always @(negedge clk) begin
        if (hold_taken != hold_request) begin
            hold_left <= HOLD_CYCLES;
            hold_taken <= hold_request;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else
            out_stall <= (pick_gap() != 0);
    end

    // Monitor: sampled on the rising edge.
    always @(posedge clk) begin
        out_item_t exp_item;
        accepted_in <= rst_n && in_valid && !in_stall;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
                predict_transfer(in_data);
            if (out_valid && !out_stall) begin
                if (expected_scores.size() == 0) begin
                    $error("unexpected result transfer: log_score %0d", out_data.log_score);
                    fail_seen = 1'b1;
                end else begin
                    exp_item = expected_scores.pop_front();
                    if (out_data.log_score !== exp_item.log_score) begin
                        $error("log_score expected %0d actual %0d",
                               exp_item.log_score, out_data.log_score);
                        fail_seen = 1'b1;
                    end
                    if (out_data.observations !== exp_item.observations) begin
                        $error("observations expected %0d actual %0d",
                               exp_item.observations, out_data.observations);
                        fail_seen = 1'b1;
                    end
                    if (out_data.status !== exp_item.status) begin
                        $error("status expected %0d actual %0d",
                               exp_item.status, out_data.status);
                        fail_seen = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dirichlet_count_log_score test failed");
            $finish;
        end
    end

    function automatic in_item_t make_item(opcode_t op, logic [1:0] sym, bit last_flag);
        in_item_t it;
        it.opcode = op;
        it.symbol = sym;
        it.prior_column = 3'($urandom_range(7));
        it.prior_value = 16'($urandom);
        it.last = last_flag;
        return it;
    endfunction

    function automatic in_item_t make_load(int col, int sym, int value, bit last_flag);
        in_item_t it;
        it = make_item(OP_LOAD, 2'(sym), last_flag);
        it.prior_column = 3'(col);
        it.prior_value = 16'(value);
        return it;
    endfunction

    task automatic wait_drained();
        wait (pending_items.size() == 0 && !in_valid && expected_scores.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_columns(input int value);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 4'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        cols_reg = value;
    endtask

    // Well-formed words of whole observations, with some random-length words and loads, until n_items are queued.
    task automatic queue_random(input int n_items);
        int made;
        int len;
        int r;
        opcode_t op;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(99);
            if (r < 85) begin
                len = ((cols_reg == 0) ? 1 : (cols_reg > 8 ? 8 : cols_reg))
                      * $urandom_range(3, 1);
                if ($urandom_range(9) == 0)
                    len = $urandom_range(12, 1);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(99);
                    op = (r < 45) ? OP_ADD : (r < 58) ? OP_REMOVE : OP_SCORE;
                    add_pending(make_item(op, 2'($urandom_range(3)), i == len - 1));
                    made++;
                end
            end else begin
                r = $urandom_range(3);
                add_pending(make_load($urandom_range(7), $urandom_range(3),
                    (r == 0) ? $urandom_range(65535) : $urandom_range(2048, 64),
                    $urandom_range(1)));
                made++;
            end
        end
    endtask

    initial begin
        int phase_cols[6] = '{1, 0, 15, 3, 5, 8};
        for (int c = 0; c < MAX_COLUMNS; c++)
            for (int k = 0; k <= ALPHABET; k++) begin
                count_tab[c][k] = 0;
                prior_tab[c][k] = 0;
            end
        word_col = 0;
        word_score = 0;
        word_len = 0;
        word_sat = 1'b0;
        cols_reg = 8;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: score against empty priors, remove at zero, load extremes.
        add_pending(make_item(OP_SCORE, 2'd0, 1'b0));
        add_pending(make_item(OP_REMOVE, 2'd3, 1'b0));
        add_pending(make_item(OP_ADD, 2'd1, 1'b1));
        add_pending(make_load(0, 0, 0, 1'b1));
        add_pending(make_load(7, 3, 65535, 1'b0));
        add_pending(make_load(7, 2, 65535, 1'b0));
        add_pending(make_load(7, 1, 65535, 1'b0));
        add_pending(make_load(7, 0, 65535, 1'b0));
        for (int c = 0; c < 7; c++)
            add_pending(make_load(c, c % 4, 256 + c * 100, 1'b0));
        for (int i = 0; i < 8; i++)
            add_pending(make_item(OP_SCORE, 2'(i % 4), i == 7));
        for (int i = 0; i < 8; i++)
            add_pending(make_item(i < 4 ? OP_ADD : OP_REMOVE, 2'(i % 4), i == 7));

        // Priors for every column and symbol so that later scores are finite.
        for (int c = 0; c < MAX_COLUMNS; c++)
            for (int s = 0; s < ALPHABET; s++)
                add_pending(make_load(c, s, $urandom_range(1024, 32), 1'b0));

        wait_drained();
        add_pending(make_item(OP_SCORE, 2'd2, 1'b0));
        add_pending(make_item(OP_REMOVE, 2'd2, 1'b0));
        add_pending(make_item(OP_SCORE, 2'd1, 1'b1));

        foreach (phase_cols[p]) begin
            write_columns(phase_cols[p]);
            queue_random(250);
            if (p == 2) begin
                // Long receiver hold-off while the sender keeps offering.
                wait (pending_items.size() < 200);
                hold_request++;
            end
        end

        wait_drained();
        if (!fail_seen)
            $display("dirichlet_count_log_score test passed");
        else
            $display("dirichlet_count_log_score test failed");
        $finish;
    end

endmodule
